// File: hdl/pidc_pkg.sv
// Shared types, widths and constants of the three-mode PID controller.
package pidc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd5;

	// Mode codes; every other code runs proportional only.
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_FILT  = 2'd1;

	// Datapath widths.
	localparam int DIG_W  = 16;              // multiplier digit of the B operand
	localparam int A_W    = 34;              // signed A operand
	localparam int B_W    = 48;              // signed B operand, three digits
	localparam int PP_W   = A_W + DIG_W + 1; // one partial product
	localparam int PROD_W = 82;              // full A times B product
	localparam int RES_W  = PROD_W - DIG_W;  // product with fraction dropped
	localparam int DRV_W  = 68;              // exact sum of the four terms
	localparam int ERR_W  = 40;
	localparam int SUM_W  = 48;
	localparam int OUT_W  = 48;

	// Digit positions of the B operand.
	localparam logic [1:0] CHUNK_LO  = 2'd0;
	localparam logic [1:0] CHUNK_MID = 2'd1;
	localparam logic [1:0] CHUNK_HI  = 2'd2;

	// Fixed-point constants.
	localparam int INTEG_LIMIT = 10000;
	localparam logic signed [A_W-1:0] FILT_OLD = 34'sd45875;
	localparam logic signed [A_W-1:0] FILT_NEW = 34'sd19661;
	localparam logic [16:0] Q_ONE = 17'h10000;
	localparam logic signed [SUM_W:0] SUM_LIM = 49'(INTEG_LIMIT * 65536);
	localparam logic signed [SUM_W:0] SUM_LIM_NEG = -SUM_LIM;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 82'sd32768;
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Where a finished product goes.
	typedef enum logic [1:0] {
		DEST_NONE,
		DEST_KD,
		DEST_ERR,
		DEST_DRV
	} dest_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [1:0] chunk;
		dest_t      dest;
	} mac_op_t;

	typedef struct packed {
		logic  valid;
		dest_t dest;
	} mac_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_KD,
		ST_FOLD,
		ST_FNEW,
		ST_WAIT1,
		ST_WAIT2,
		ST_TP,
		ST_TI,
		ST_TD,
		ST_TA,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DONE
	} state_t;

endpackage

// File: hdl/pidc_mac.sv
// Shared multiply-accumulate unit: one 34 by 17 bit digit product per cycle, rounded result.
module pidc_mac import pidc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_op_t                 op,
	input  logic signed [A_W-1:0]   a_op,
	input  logic signed [B_W-1:0]   b_op,
	output mac_res_t                res,
	output logic signed [RES_W-1:0] res_value
);

	logic signed [DIG_W:0]    digit;
	logic signed [PP_W-1:0]   pp_s1;
	mac_op_t                  op_s1;
	logic signed [PROD_W-1:0] pp_ext;
	logic signed [PROD_W-1:0] pp_shift;
	logic signed [PROD_W-1:0] acc_base;
	logic signed [PROD_W-1:0] prod_q;
	mac_res_t                 res_q;

	// The lower digits are unsigned, the top digit carries the sign of B.
	always_comb begin
		case (op.chunk)
			CHUNK_LO:  digit = {1'b0, b_op[DIG_W-1:0]};
			CHUNK_MID: digit = {1'b0, b_op[2*DIG_W-1:DIG_W]};
			default:   digit = {b_op[B_W-1], b_op[B_W-1:2*DIG_W]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			res_q <= '0;
		end else begin
			op_s1 <= op;
			res_q.valid <= op_s1.valid && op_s1.last;
			res_q.dest <= op_s1.dest;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= a_op * digit;
		if (op_s1.valid) begin
			prod_q <= acc_base + pp_shift;
		end
	end

	always_comb begin
		pp_ext = PROD_W'(pp_s1);
		case (op_s1.chunk)
			CHUNK_LO:  pp_shift = pp_ext;
			CHUNK_MID: pp_shift = pp_ext <<< DIG_W;
			default:   pp_shift = pp_ext <<< (2 * DIG_W);
		endcase
		// Starting from one half makes the final shift round to nearest, ties up.
		acc_base = op_s1.first ? ROUND_HALF : prod_q;
	end

	assign res = res_q;
	assign res_value = prod_q[PROD_W-1:DIG_W];

endmodule

// File: hdl/pid_controller_three_mode.sv
// Top level of the three-mode PID controller: configuration, sequencer and state.
//
// One request on the input channel (sample_a, sample_b) yields exactly one
// request on the output channel (drive, signed Q32.16, saturated to 48 bits).
// Both channels use valid and stall; a request moves at a clock edge with
// valid high and stall low. Configuration registers are written through
// cfg_we, cfg_index and cfg_data, one register per edge; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// All multiplication runs through one shared multiply-accumulate unit that takes
// one 16-bit digit of its B operand per cycle, so every product takes two or
// three digits and the sequencer walks through the products of one request.
// in_stall is high from the accept until the result is loaded into the output
// register, so a new request can be taken in the cycle after that load.
// The output register holds a finished result while out_stall is high; the
// next request is still taken and runs, and only its final load waits.
// Reset clears the configuration, the error history and the integral sum,
// and leaves the block idle with no output pending.
module pid_controller_three_mode import pidc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [15:0]           sample_a,
	input  logic signed [15:0]           sample_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OUT_W-1:0]      drive,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	logic [1:0]         mode_q;
	logic signed [31:0] gain_prop_q;
	logic signed [31:0] gain_integ_q;
	logic signed [31:0] gain_deriv_q;
	logic [16:0]        alpha_q;
	logic signed [15:0] setpoint_q;

	state_t     state_q;
	state_t     state_nxt;
	logic [1:0] k_q;
	logic [1:0] k_nxt;

	logic signed [ERR_W-1:0] err_now_q;
	logic signed [ERR_W-1:0] err_prev_q;
	logic signed [SUM_W-1:0] err_sum_q;
	logic signed [17:0]      raw_q;
	logic signed [A_W-1:0]   kd_q;
	logic signed [ERR_W:0]   diff_q;
	logic signed [DRV_W-1:0] drv_q;
	logic signed [OUT_W-1:0] drive_q;
	logic                    out_valid_q;

	logic                    in_acc;
	logic                    full_pid;
	logic signed [17:0]      raw_in;
	logic [16:0]             alpha_sat;
	logic [16:0]             one_minus_alpha;
	logic signed [SUM_W:0]   sum_add;
	logic signed [SUM_W-1:0] sum_nxt;
	logic signed [ERR_W:0]   diff_nxt;
	logic signed [OUT_W-1:0] drive_sat;
	logic                    upd_en;
	logic                    done_load;

	mac_op_t                 op;
	logic signed [A_W-1:0]   a_op;
	logic signed [B_W-1:0]   b_op;
	mac_res_t                res;
	logic signed [RES_W-1:0] res_value;

	pidc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.a_op      (a_op),
		.b_op      (b_op),
		.res       (res),
		.res_value (res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			gain_prop_q <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			alpha_q <= '0;
			setpoint_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       mode_q <= cfg_data[1:0];
				REG_GAIN_PROP:  gain_prop_q <= cfg_data;
				REG_GAIN_INTEG: gain_integ_q <= cfg_data;
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				REG_ALPHA:      alpha_q <= cfg_data[16:0];
				REG_SETPOINT:   setpoint_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign full_pid = (mode_q == MODE_PLAIN) || (mode_q == MODE_FILT);

	always_comb begin
		raw_in = 18'(setpoint_q) - 18'(sample_a)
			- ((mode_q == MODE_FILT) ? 18'(sample_b) : 18'sd0);
		alpha_sat = alpha_q[16] ? Q_ONE : alpha_q;
		one_minus_alpha = Q_ONE - alpha_sat;
		sum_add = 49'(err_sum_q) + 49'(err_now_q);
		diff_nxt = 41'(err_now_q) - 41'(err_prev_q);

		// Filtered mode clamps the integral to the fixed INTEG_LIMIT; plain mode saturates.
		if (mode_q == MODE_FILT) begin
			if (sum_add > SUM_LIM) begin
				sum_nxt = SUM_LIM[SUM_W-1:0];
			end else if (sum_add < SUM_LIM_NEG) begin
				sum_nxt = SUM_LIM_NEG[SUM_W-1:0];
			end else begin
				sum_nxt = sum_add[SUM_W-1:0];
			end
		end else if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
			sum_nxt = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_nxt = sum_add[SUM_W-1:0];
		end

		if (drv_q[DRV_W-1:OUT_W-1] == {(DRV_W-OUT_W+1){drv_q[DRV_W-1]}}) begin
			drive_sat = drv_q[OUT_W-1:0];
		end else begin
			drive_sat = drv_q[DRV_W-1] ? OUT_MIN : OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			state_q <= state_nxt;
			k_q <= k_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		k_nxt = k_q;
		op = '0;
		a_op = '0;
		b_op = '0;
		upd_en = 1'b0;
		done_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					k_nxt = CHUNK_LO;
					case (mode_q)
						MODE_PLAIN: state_nxt = ST_UPD;
						MODE_FILT:  state_nxt = ST_KD;
						default:    state_nxt = ST_TP;
					endcase
				end
			end
			ST_UPD: begin
				upd_en = 1'b1;
				state_nxt = (mode_q == MODE_FILT) ? ST_TP : ST_KD;
			end
			ST_KD: begin
				op.valid = 1'b1;
				op.chunk = k_q;
				op.first = (k_q == CHUNK_LO);
				op.last = (k_q == CHUNK_MID);
				op.dest = DEST_KD;
				a_op = 34'(gain_deriv_q);
				b_op = {31'b0, one_minus_alpha};
				if (k_q == CHUNK_MID) begin
					k_nxt = CHUNK_LO;
					state_nxt = (mode_q == MODE_FILT) ? ST_FOLD : ST_TP;
				end else begin
					k_nxt = k_q + 2'd1;
				end
			end
			ST_FOLD: begin
				op.valid = 1'b1;
				op.chunk = k_q;
				op.first = (k_q == CHUNK_LO);
				op.dest = DEST_NONE;
				a_op = FILT_OLD;
				b_op = 48'(err_now_q);
				if (k_q == CHUNK_HI) begin
					// The new-sample term has a zero low digit, so it starts one digit up.
					k_nxt = CHUNK_MID;
					state_nxt = ST_FNEW;
				end else begin
					k_nxt = k_q + 2'd1;
				end
			end
			ST_FNEW: begin
				op.valid = 1'b1;
				op.chunk = k_q;
				op.last = (k_q == CHUNK_HI);
				op.dest = DEST_ERR;
				a_op = FILT_NEW;
				b_op = {32'(raw_q), 16'h0};
				if (k_q == CHUNK_HI) begin
					k_nxt = CHUNK_LO;
					state_nxt = ST_WAIT1;
				end else begin
					k_nxt = k_q + 2'd1;
				end
			end
			ST_WAIT1: state_nxt = ST_WAIT2;
			ST_WAIT2: state_nxt = ST_UPD;
			ST_TP, ST_TI, ST_TD, ST_TA: begin
				op.valid = 1'b1;
				op.chunk = k_q;
				op.first = (k_q == CHUNK_LO);
				op.last = (k_q == CHUNK_HI);
				op.dest = DEST_DRV;
				case (state_q)
					ST_TP: begin
						a_op = 34'(gain_prop_q);
						b_op = 48'(err_now_q);
					end
					ST_TI: begin
						a_op = 34'(gain_integ_q);
						b_op = err_sum_q;
					end
					ST_TD: begin
						a_op = kd_q;
						b_op = 48'(diff_q);
					end
					default: begin
						a_op = {17'b0, alpha_sat};
						b_op = 48'(err_prev_q);
					end
				endcase
				if (k_q == CHUNK_HI) begin
					k_nxt = CHUNK_LO;
					case (state_q)
						ST_TP:   state_nxt = full_pid ? ST_TI : ST_DRAIN1;
						ST_TI:   state_nxt = ST_TD;
						ST_TD:   state_nxt = ST_TA;
						default: state_nxt = ST_DRAIN1;
					endcase
				end else begin
					k_nxt = k_q + 2'd1;
				end
			end
			ST_DRAIN1: state_nxt = ST_DRAIN2;
			ST_DRAIN2: state_nxt = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					done_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_now_q <= '0;
			err_prev_q <= '0;
			err_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && mode_q != MODE_FILT) begin
				err_now_q <= {24'(raw_in), 16'h0};
			end else if (res.valid && res.dest == DEST_ERR) begin
				err_now_q <= res_value[ERR_W-1:0];
			end
			if (upd_en) begin
				err_sum_q <= sum_nxt;
			end
			if (done_load && full_pid) begin
				err_prev_q <= err_now_q;
			end
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q <= raw_in;
		end
		if (res.valid && res.dest == DEST_KD) begin
			kd_q <= res_value[A_W-1:0];
		end
		if (upd_en) begin
			diff_q <= diff_nxt;
		end
		if (in_acc) begin
			drv_q <= '0;
		end else if (res.valid && res.dest == DEST_DRV) begin
			drv_q <= drv_q + DRV_W'(res_value);
		end
		if (done_load) begin
			drive_q <= drive_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block did not leave idle after taking a request");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> state_q != ST_IDLE)
		else $error("product finished while the sequencer was idle");

	a_drained_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !res.valid)
		else $error("output loaded before the last product was accumulated");

	a_hold_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && out_stall |=> state_q == ST_DONE)
		else $error("new result loaded over a pending one");

endmodule
